>>> hdl/mds_pkg.sv
// ----------------------------------------------------------------------------
// mds_pkg
// Shared types, constants and arithmetic helpers for the Mahalanobis
// distance stream block.
// ----------------------------------------------------------------------------
`default_nettype none
package mds_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = 3;
	localparam int DIM_W     = 4;
	localparam int SQ_STEPS  = 32;
	localparam int SQ_CNT_W  = 5;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_MEAN   = 2'd1;
	localparam logic [1:0] KIND_COV    = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic             wr_mean;
		logic             wr_cov;
		logic             wr_diff;
		logic [IDX_W-1:0] row_addr;
		logic [IDX_W-1:0] col_addr;
		logic [IDX_W-1:0] diff_addr;
		logic             rd;
		logic [IDX_W-1:0] rd_row;
		logic [IDX_W-1:0] rd_col;
		logic [IDX_W-1:0] rd_diff;
		logic             mul_mac;
		logic             acc_mac;
		logic             acc_clr;
		logic             mul_row;
		logic             acc_tot;
		logic             tot_clr;
		logic             sq_init;
		logic             sq_step;
		logic             out_load;
		logic             out_miss;
	} mds_cmd_t;

	typedef struct packed {
		logic out_busy;
	} mds_stat_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32_of64(input logic signed [63:0] v);
		if (v[63] && !(&v[62:31]))
			return {1'b1, 31'd0};
		if (!v[63] && (|v[62:31]))
			return {1'b0, {31{1'b1}}};
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31])
			return s[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		return s[31:0];
	endfunction

endpackage
`default_nettype wire

>>> hdl/mds_dp.sv
// ----------------------------------------------------------------------------
// mds_dp
// Datapath: table memories, difference store, shared multiply-accumulate,
// bit-pair square root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module mds_dp
	import mds_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mds_cmd_t           cmd,
	input  wire logic signed [31:0] value,
	output      mds_stat_t          stat,
	output      logic               m_tvalid,
	input  wire logic               m_tready,
	output      logic [31:0]        distance,
	output      logic               missing
);

	logic signed [31:0] mean_q [MAX_DIM];
	logic signed [31:0] cov_mem [MAX_DIM*MAX_DIM];
	logic signed [31:0] diff_mem [MAX_DIM];

	logic signed [31:0] cov_rd_q;
	logic signed [31:0] d_rd_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] tot_q;
	logic [63:0]        sq_n_q;
	logic [63:0]        sq_root_q;
	logic [63:0]        sq_bit_q;
	logic               valid_q;
	logic [31:0]        dist_q;
	logic               miss_q;

	logic signed [31:0] row_w;
	logic [63:0]        sq_t;

	assign row_w = sat32_of64(acc_q >>> 16);
	assign sq_t  = sq_root_q + sq_bit_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_mean)
			mean_q[cmd.row_addr] <= value;
		if (cmd.wr_cov)
			cov_mem[{cmd.row_addr, cmd.col_addr}] <= value;
		if (cmd.wr_diff)
			diff_mem[cmd.diff_addr] <= sat_sub32(value, mean_q[cmd.diff_addr]);
		if (cmd.rd) begin
			cov_rd_q <= cov_mem[{cmd.rd_row, cmd.rd_col}];
			d_rd_q   <= diff_mem[cmd.rd_diff];
		end
		if (cmd.mul_mac)
			prod_q <= cov_rd_q * d_rd_q;
		else if (cmd.mul_row)
			prod_q <= d_rd_q * row_w;
		if (cmd.acc_clr)
			acc_q <= '0;
		else if (cmd.acc_mac)
			acc_q <= sat_add64(acc_q, prod_q);
		if (cmd.tot_clr)
			tot_q <= '0;
		else if (cmd.acc_tot)
			tot_q <= sat_add64(tot_q, prod_q);
		if (cmd.sq_init) begin
			sq_n_q    <= tot_q[63] ? 64'd0 : tot_q;
			sq_root_q <= '0;
			sq_bit_q  <= 64'd1 << 62;
		end else if (cmd.sq_step) begin
			if (sq_n_q >= sq_t) begin
				sq_n_q    <= sq_n_q - sq_t;
				sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
			end else begin
				sq_root_q <= sq_root_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		if (cmd.out_load) begin
			dist_q <= cmd.out_miss ? 32'd0 : sq_root_q[31:0];
			miss_q <= cmd.out_miss;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign stat.out_busy = valid_q && !m_tready;
	assign m_tvalid      = valid_q;
	assign distance      = dist_q;
	assign missing       = miss_q;

endmodule
`default_nettype wire

>>> hdl/mds_ctrl.sv
// ----------------------------------------------------------------------------
// mds_ctrl
// Controller: input handshake, element counting, dimension register and
// the row/column sequencing of the shared multiply-accumulate.
// ----------------------------------------------------------------------------
`default_nettype none
module mds_ctrl
	import mds_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [DIM_W-1:0] cfg_wdata,
	input  wire logic             s_tvalid,
	output      logic             s_tready,
	input  wire logic [1:0]       kind,
	input  wire logic [IDX_W-1:0] row_index,
	input  wire logic [IDX_W-1:0] col_index,
	input  wire logic             is_missing,
	input  wire mds_stat_t        stat,
	output      mds_cmd_t         cmd
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_RD   = 10'b0000000010,
		ST_MUL  = 10'b0000000100,
		ST_ACC  = 10'b0000001000,
		ST_RDR  = 10'b0000010000,
		ST_MULR = 10'b0000100000,
		ST_ACCR = 10'b0001000000,
		ST_SQI  = 10'b0010000000,
		ST_SQ   = 10'b0100000000,
		ST_OUT  = 10'b1000000000
	} state_t;

	state_t              state_q, state_d;
	logic [DIM_W-1:0]    dim_q;
	logic [DIM_W-1:0]    cnt_q, cnt_d;
	logic                seen_q, seen_d;
	logic                res_miss_q, res_miss_d;
	logic [IDX_W-1:0]    i_q, i_d, j_q, j_d;
	logic [SQ_CNT_W-1:0] sq_q, sq_d;
	logic                acc_in;
	logic [DIM_W-1:0]    cnt_inc;
	logic                j_last, i_last;

	assign s_tready = (state_q == ST_IDLE);
	assign acc_in   = s_tvalid && s_tready;
	assign cnt_inc  = cnt_q + DIM_W'(1);
	assign j_last   = (DIM_W'(j_q) + DIM_W'(1)) == dim_q;
	assign i_last   = (DIM_W'(i_q) + DIM_W'(1)) == dim_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		seen_d     = seen_q;
		res_miss_d = res_miss_q;
		i_d        = i_q;
		j_d        = j_q;
		sq_d       = sq_q;
		cmd        = '0;
		cmd.row_addr  = row_index;
		cmd.col_addr  = col_index;
		cmd.diff_addr = cnt_q[IDX_W-1:0];
		cmd.rd_row    = i_q;
		cmd.rd_col    = j_q;
		cmd.rd_diff   = j_q;
		cmd.out_miss  = res_miss_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_in) begin
					cmd.wr_mean = (kind == KIND_MEAN);
					cmd.wr_cov  = (kind == KIND_COV);
					if (kind == KIND_SAMPLE) begin
						cmd.wr_diff = 1'b1;
						if (cnt_inc >= dim_q) begin
							cnt_d      = '0;
							seen_d     = 1'b0;
							res_miss_d = seen_q || is_missing;
							i_d        = '0;
							j_d        = '0;
							cmd.acc_clr = 1'b1;
							cmd.tot_clr = 1'b1;
							state_d    = (seen_q || is_missing) ? ST_OUT : ST_RD;
						end else begin
							cnt_d  = cnt_inc;
							seen_d = seen_q || is_missing;
						end
					end
				end
			end
			ST_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_mac = 1'b1;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_mac = 1'b1;
				if (j_last) begin
					state_d = ST_RDR;
				end else begin
					j_d     = j_q + IDX_W'(1);
					state_d = ST_RD;
				end
			end
			ST_RDR: begin
				cmd.rd      = 1'b1;
				cmd.rd_diff = i_q;
				state_d     = ST_MULR;
			end
			ST_MULR: begin
				cmd.mul_row = 1'b1;
				state_d     = ST_ACCR;
			end
			ST_ACCR: begin
				cmd.acc_tot = 1'b1;
				cmd.acc_clr = 1'b1;
				j_d         = '0;
				if (i_last) begin
					state_d = ST_SQI;
				end else begin
					i_d     = i_q + IDX_W'(1);
					state_d = ST_RD;
				end
			end
			ST_SQI: begin
				cmd.sq_init = 1'b1;
				sq_d        = '0;
				state_d     = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq_step = 1'b1;
				sq_d        = sq_q + SQ_CNT_W'(1);
				if (sq_q == SQ_CNT_W'(SQ_STEPS - 1))
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dim_q      <= DIM_W'(MAX_DIM);
			cnt_q      <= '0;
			seen_q     <= 1'b0;
			res_miss_q <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			sq_q       <= '0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			seen_q     <= seen_d;
			res_miss_q <= res_miss_d;
			i_q        <= i_d;
			j_q        <= j_d;
			sq_q       <= sq_d;
			if (cfg_we) begin
				if (cfg_wdata == '0)
					dim_q <= DIM_W'(1);
				else if (cfg_wdata > DIM_W'(MAX_DIM))
					dim_q <= DIM_W'(MAX_DIM);
				else
					dim_q <= cfg_wdata;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/mahalanobis_distance_stream.sv
// ----------------------------------------------------------------------------
// mahalanobis_distance_stream
// Streaming fixed-point Mahalanobis distance with loadable mean and
// inverse-covariance tables.
// ----------------------------------------------------------------------------
// Load transactions (mean, inverse covariance) and sample elements are taken
// one per cycle while the block is idle. The element that completes a vector
// of k = dim_in_use elements starts the computation, during which s_tready is
// low: k*k multiply-accumulates (read, multiply, accumulate) plus a read,
// multiply and accumulate per row, all through one shared 32x32 multiplier,
// then the bit-pair square root and the load of the output register.
// A vector with a missing element skips the arithmetic. The result sits in an
// output register, so new transactions are taken while it waits.
`default_nettype none
module mahalanobis_distance_stream
	import mds_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,  // dim_in_use
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,    // row_index[2:0], col_index[5:3], value[37:6], zero pad
	input  wire logic [2:0]  s_tuser,    // kind[1:0], is_missing[2]
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,    // distance[31:0]
	output      logic        m_tuser     // missing
);

	mds_cmd_t  cmd;
	mds_stat_t stat;

	mds_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.kind       (s_tuser[1:0]),
		.row_index  (s_tdata[2:0]),
		.col_index  (s_tdata[5:3]),
		.is_missing (s_tuser[2]),
		.stat       (stat),
		.cmd        (cmd)
	);

	mds_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.value    (s_tdata[37:6]),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.distance (m_tdata),
		.missing  (m_tuser)
	);

endmodule
`default_nettype wire

>>> tb/mahalanobis_distance_stream_tb.sv
// ----------------------------------------------------------------------------
// mahalanobis_distance_stream_tb
// Self-checking bench: streams load and sample transactions under several
// dim_in_use settings and idle mixes, predicts every distance in a local
// fixed-point model of the block, and compares each output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mahalanobis_distance_stream_tb;
	import mds_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic        miss;
	} vec_item_t;

	typedef struct packed {
		logic [31:0] distance;
		logic        missing;
	} dist_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [3:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	mahalanobis_distance_stream uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	vec_item_t    pending_items[$];
	dist_result_t expected_dist[$];
	vec_item_t    on_bus;
	int           send_idle = 0;
	int           recv_idle = 0;
	int           hold_request = 0;
	int           hold_cnt = 0;
	int           errors = 0;

	// local copy of the block state
	int          mean_vec[MAX_DIM];
	int          icov[MAX_DIM][MAX_DIM];
	int          diff_vec[MAX_DIM];
	int unsigned elem_cnt = 0;
	bit          miss_seen = 0;
	int unsigned dim_k = MAX_DIM;

	function automatic longint add_sat64(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic int clip32(longint v);
		if (v > 64'sd2147483647)
			return 32'h7fffffff;
		if (v < -64'sd2147483648)
			return 32'h80000000;
		return int'(v);
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] b;
		root = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= root + b) begin
				n = n - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] quad_form_sqrt(int unsigned k);
		longint total;
		longint acc;
		int     row_sum;
		total = 0;
		for (int i = 0; i < k; i++) begin
			acc = 0;
			for (int j = 0; j < k; j++)
				acc = add_sat64(acc, longint'(icov[i][j]) * longint'(diff_vec[j]));
			row_sum = clip32(acc >>> 16);
			total = add_sat64(total, longint'(diff_vec[i]) * longint'(row_sum));
		end
		if (total < 0)
			return 32'd0;
		return 32'(floor_sqrt(total));
	endfunction

	function automatic void absorb_item(vec_item_t it);
		dist_result_t r;
		case (it.kind)
			KIND_MEAN: mean_vec[it.row] = it.value;
			KIND_COV:  icov[it.row][it.col] = it.value;
			KIND_SAMPLE: begin
				if (elem_cnt < MAX_DIM)
					diff_vec[elem_cnt] = clip32(longint'(signed'(it.value)) -
						longint'(mean_vec[elem_cnt]));
				if (it.miss)
					miss_seen = 1;
				elem_cnt++;
				if (elem_cnt >= dim_k) begin
					r.missing = miss_seen;
					r.distance = miss_seen ? 32'd0 : quad_form_sqrt(dim_k);
					expected_dist.push_back(r);
					elem_cnt = 0;
					miss_seen = 0;
				end
			end
			default: ;
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_item(on_bus);
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
					on_bus = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, on_bus.value, on_bus.col, on_bus.row};
					s_tuser <= {on_bus.miss, on_bus.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_dist.size() == 0) begin
					errors++;
					$display("%0t: unexpected result distance=%h missing=%b",
						$time, m_tdata, m_tuser);
				end else begin
					dist_result_t e;
					e = expected_dist.pop_front();
					if (m_tdata !== e.distance) begin
						errors++;
						$display("%0t: distance expected %h actual %h",
							$time, e.distance, m_tdata);
					end
					if (m_tuser !== e.missing) begin
						errors++;
						$display("%0t: missing expected %b actual %b",
							$time, e.missing, m_tuser);
					end
				end
			end
			if (hold_request > 0) begin
				hold_cnt = hold_request;
				hold_request = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return $urandom;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
		endcase
	endfunction

	function automatic vec_item_t make_item(logic [1:0] kind, logic [2:0] row,
			logic [2:0] col, logic [31:0] value, logic miss);
		vec_item_t it;
		it.kind = kind;
		it.row = row;
		it.col = col;
		it.value = value;
		it.miss = miss;
		return it;
	endfunction

	task automatic wait_idle();
		wait (pending_items.size() == 0 && !s_tvalid && expected_dist.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_dim(logic [3:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		dim_k = (v == 0) ? 1 : (v > MAX_DIM) ? MAX_DIM : v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_sample(logic [31:0] v, logic miss);
		pending_items.push_back(make_item(KIND_SAMPLE, 3'($urandom), 3'($urandom), v, miss));
	endtask

	// mostly whole vectors with random content, plus stray loads and noise
	task automatic queue_random(int n);
		int r;
		int made;
		made = 0;
		while (made < n) begin
			r = $urandom_range(99);
			if (r < 75) begin
				for (int i = 0; i < dim_k; i++)
					queue_sample(pick_value(), $urandom_range(39) == 0);
				made += dim_k;
			end else if (r < 83) begin
				pending_items.push_back(make_item(KIND_MEAN, 3'($urandom), 3'($urandom),
					pick_value(), 1'($urandom)));
				made++;
			end else if (r < 91) begin
				pending_items.push_back(make_item(KIND_COV, 3'($urandom), 3'($urandom),
					($urandom_range(3) == 0) ? pick_value()
						: 32'($urandom_range(1 << 17)), 1'($urandom)));
				made++;
			end else if (r < 95) begin
				pending_items.push_back(make_item(KIND_UNUSED, 3'($urandom), 3'($urandom),
					$urandom, 1'($urandom)));
			end else begin
				queue_sample(pick_value(), 1'($urandom));
				made++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// every table entry written before any sample reads it
		for (int i = 0; i < MAX_DIM; i++)
			pending_items.push_back(make_item(KIND_MEAN, 3'(i), 3'($urandom),
				32'($signed($urandom_range(1 << 18)) - (1 << 17)), 1'b0));
		for (int i = 0; i < MAX_DIM; i++)
			for (int j = 0; j < MAX_DIM; j++)
				pending_items.push_back(make_item(KIND_COV, 3'(i), 3'(j),
					(i == j) ? 32'h0001_0000 : 32'($urandom_range(1 << 14)), 1'b0));

		// directed: extremes, saturated difference, missing, unused kind
		for (int i = 0; i < MAX_DIM; i++)
			queue_sample(32'h7fffffff, 1'b0);
		pending_items.push_back(make_item(KIND_MEAN, 3'd0, 3'd5, 32'h7fffffff, 1'b0));
		pending_items.push_back(make_item(KIND_UNUSED, 3'd7, 3'd7, 32'hffffffff, 1'b1));
		for (int i = 0; i < MAX_DIM; i++)
			queue_sample(32'h80000000, 1'b0);
		queue_sample(32'd0, 1'b0);
		queue_sample(32'd0, 1'b1);
		// load in the middle of a vector
		pending_items.push_back(make_item(KIND_COV, 3'd7, 3'd0, 32'h80000000, 1'b1));
		for (int i = 0; i < 6; i++)
			queue_sample(pick_value(), 1'b0);
		write_dim(4'd8);

		// k = 1 via a write of zero
		write_dim(4'd0);
		queue_sample(32'h0003_0000, 1'b0);
		queue_sample(32'hfffd_0000, 1'b1);
		queue_random(40);

		// partial vector left over, then a shorter length completes it
		write_dim(4'd15);
		send_idle = 56;
		queue_random(90);
		queue_sample(32'h0001_0000, 1'b1);
		queue_sample(32'h0002_0000, 1'b0);
		queue_sample(32'h0003_0000, 1'b0);

		write_dim(4'd3);
		send_idle = 0;
		recv_idle = 56;
		queue_random(90);

		// long receiver hold so the output register fills and input stalls
		write_dim(4'd2);
		recv_idle = 0;
		hold_request = 1500;
		queue_random(90);

		write_dim(4'd5);
		send_idle = 23;
		recv_idle = 23;
		queue_random(90);

		write_dim(4'd8);
		send_idle = 0;
		recv_idle = 0;
		queue_random(90);

		wait (pending_items.size() == 0 && !s_tvalid && expected_dist.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_dist.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
